@@ hw/rtl/rkn_pkg.sv @@
package rkn_pkg;

  localparam int DATA_W = 64;
  localparam int STEP_W = 63;
  localparam int CFG_IDX_W = 2;

  localparam int OPND_W = 65;
  localparam int SUM_W = 66;
  localparam int TSUM_W = 67;
  localparam int PROD_W = 96;
  localparam int RES_W = 97;

  localparam int MUL_SPLIT = 32;
  localparam int MUL_AHI_W = OPND_W - MUL_SPLIT;
  localparam int MUL_BHI_W = STEP_W - MUL_SPLIT;
  localparam int MUL_HH_W = MUL_AHI_W + MUL_BHI_W;
  localparam int MUL_HL_W = MUL_AHI_W + MUL_SPLIT + 1;
  localparam int MUL_LH_W = MUL_SPLIT + MUL_BHI_W;
  localparam int MUL_LL_W = 2 * MUL_SPLIT;
  localparam int MUL_MID_W = MUL_HL_W + 1;
  localparam int MUL_LAT = 3;

  localparam int DIV_W = RES_W;
  localparam int DIV_UW = DIV_W + 1;
  localparam int DIV_CH = 14;
  localparam int DIV_STAGES = DIV_UW / DIV_CH;
  localparam int DIV_RW = 3;
  localparam int DIV_CW = DIV_CH + DIV_RW;
  localparam int DIV_RECIP_W = 18;
  localparam int DIV_PW = DIV_CW + DIV_RECIP_W;
  localparam int DIV_RSH = 20;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(174763);
  localparam logic [DIV_UW-1:0] DIV_BIAS = DIV_UW'(3) << (DIV_W - 2);
  localparam logic [DIV_UW-1:0] DIV_UNBIAS = DIV_UW'(1) << (DIV_W - 3);
  localparam int DIV_LAT = DIV_STAGES + 2;

  localparam int S_SUM = 1;
  localparam int S_QS = S_SUM + DIV_LAT;
  localparam int S_OPM = S_QS + 1;
  localparam int S_POS = S_OPM + MUL_LAT;
  localparam int S_P = MUL_LAT;
  localparam int S_T = S_P + 1;
  localparam int S_QT = S_T + DIV_LAT;
  localparam int S_NV = S_QT + 1;
  localparam int S_NP = S_POS + 1;
  localparam int S_OUT = S_NP + 1;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_POS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_POS = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    STAGE_FIRST,
    STAGE_SECOND,
    STAGE_THIRD,
    STAGE_FINAL
  } stage_t;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] acceleration;
    logic signed [DATA_W-1:0] start_position;
    logic signed [DATA_W-1:0] start_velocity;
    logic signed [DATA_W-1:0] k_one;
    logic signed [DATA_W-1:0] k_two;
    logic signed [DATA_W-1:0] k_three;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_position;
    logic signed [DATA_W-1:0] new_velocity;
    logic signed [DATA_W-1:0] stage_k;
    logic                     overflow;
  } result_t;

endpackage

@@ hw/rtl/rkn_mul.sv @@
module rkn_mul
  import rkn_pkg::*;
(
  input  logic              clk,
  input  logic [OPND_W-1:0] a,
  input  logic [STEP_W-1:0] b,
  output logic [PROD_W-1:0] p
);

  logic signed [MUL_AHI_W-1:0] a_hi;
  logic [MUL_SPLIT-1:0]        a_lo;
  logic [MUL_BHI_W-1:0]        b_hi;
  logic [MUL_SPLIT-1:0]        b_lo;
  logic signed [MUL_BHI_W:0]   b_hi_s;
  logic signed [MUL_SPLIT:0]   b_lo_s;

  logic signed [MUL_HH_W-1:0]  pp_hh;
  logic signed [MUL_HL_W-1:0]  pp_hl;
  logic [MUL_LH_W-1:0]         pp_lh;
  logic [MUL_LL_W-1:0]         pp_ll;
  logic [MUL_HH_W-1:0]         hh;
  logic [MUL_MID_W-1:0]        mid;

  assign a_hi = a[OPND_W-1:MUL_SPLIT];
  assign a_lo = a[MUL_SPLIT-1:0];
  assign b_hi = b[STEP_W-1:MUL_SPLIT];
  assign b_lo = b[MUL_SPLIT-1:0];
  assign b_hi_s = {1'b0, b_hi};
  assign b_lo_s = {1'b0, b_lo};

  always_ff @(posedge clk) begin
    pp_hh <= a_hi * b_hi_s;
    pp_hl <= a_hi * b_lo_s;
    pp_lh <= a_lo * b_hi;
    pp_ll <= a_lo * b_lo;

    hh  <= pp_hh;
    mid <= {pp_hl[MUL_HL_W-1], pp_hl}
         + {{(MUL_MID_W-MUL_LH_W){1'b0}}, pp_lh}
         + {{(MUL_MID_W-MUL_SPLIT){1'b0}}, pp_ll[MUL_LL_W-1:MUL_SPLIT]};

    p <= {hh, {MUL_SPLIT{1'b0}}} + {{(PROD_W-MUL_MID_W){mid[MUL_MID_W-1]}}, mid};
  end

endmodule

@@ hw/rtl/rkn_div6.sv @@
module rkn_div6
  import rkn_pkg::*;
(
  input  logic             clk,
  input  logic [DIV_W-1:0] x,
  output logic [DIV_W-1:0] q
);

  logic [DIV_UW-1:0] num [0:DIV_STAGES-1];
  logic [DIV_RW-1:0] rem [1:DIV_STAGES-1];
  logic [DIV_UW-1:0] quo [1:DIV_STAGES];

  always_ff @(posedge clk) begin
    num[0] <= {x[DIV_W-1], x} + DIV_BIAS;
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_step
    logic [DIV_RW-1:0] rem_in;
    logic [DIV_UW-1:0] quo_in;
    logic [DIV_CW-1:0] cur;
    logic [DIV_PW-1:0] prod;
    logic [DIV_CH-1:0] qd;
    logic [DIV_CW-1:0] left;

    if (j == 1) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign quo_in = quo[j-1];
    end

    assign cur  = {rem_in, num[j-1][DIV_UW-1 -: DIV_CH]};
    assign prod = cur * DIV_RECIP;
    assign qd   = prod[DIV_RSH +: DIV_CH];
    assign left = cur - DIV_CW'({qd, 2'b00}) - DIV_CW'({qd, 1'b0});

    always_ff @(posedge clk) begin
      quo[j] <= {quo_in[DIV_UW-DIV_CH-1:0], qd};
    end

    if (j < DIV_STAGES) begin : g_carry
      always_ff @(posedge clk) begin
        num[j] <= num[j-1] << DIV_CH;
        rem[j] <= left[DIV_RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= DIV_W'(quo[DIV_STAGES] - DIV_UNBIAS);
  end

endmodule

@@ hw/rtl/rk_nystrom_stage_update.sv @@
// Stage update for a fourth-order Runge-Kutta-Nystrom integrator, one variable per item.
// An item is taken at a rising edge where start is high and busy is low; it carries
// the stage in func, the current and saved position and velocity, the fresh
// acceleration and the earlier scaled accelerations, all signed Q32.32.
// The step registers are written through cfg_write, cfg_index and cfg_data; the user must write
// them only while no item is in flight, which the block does not enforce. Writes take effect at once
// and indexes past the third are ignored. The block is a fixed 17-register pipeline and takes a new
// item in every cycle while busy is low. The result of an item appears on result, with done high,
// for a single cycle; results leave in the order taken.
// The longest path runs through the chain of the floor division by six, nine registers long,
// followed by the three-register position multiplier and the final add and clamp.
// Results that leave the signed 64-bit range are clamped and raise overflow.
// Reset clears the step registers and all valid bits, so items in flight are lost;
// busy is high during reset and in the cycle after it.
// The receiver cannot hold results off, so nothing here ever waits on the output side.
module rk_nystrom_stage_update
  import rkn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]    cfg_data
);

  function automatic logic [RES_W-1:0] sx64(input logic [DATA_W-1:0] v);
    return {{(RES_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic [DATA_W:0] sat(input logic [RES_W-1:0] v);
    logic fits;
    fits = (&v[RES_W-1:DATA_W-1]) | ~(|v[RES_W-1:DATA_W-1]);
    if (fits) begin
      return {1'b0, v[DATA_W-1:0]};
    end else if (v[RES_W-1]) begin
      return {1'b1, SAT_MIN};
    end
    return {1'b1, SAT_MAX};
  endfunction

  logic [STEP_W-1:0] time_step;
  logic [STEP_W-1:0] first_position_step;
  logic [STEP_W-1:0] second_position_step;

  logic [S_OUT:0] vld;

  item_t             in_r;
  logic [1:0]        func_p [1:S_NP];
  logic [DATA_W-1:0] base_p [1:S_POS];
  logic [DATA_W-1:0] nvb_p  [1:S_QT];
  logic [OPND_W-1:0] ope_p  [1:S_QS];
  logic [TSUM_W-1:0] k23_p  [2:S_P];
  logic [PROD_W-1:0] p_p    [S_P+1:S_NP];

  logic [SUM_W-1:0]  s_sum;
  logic [OPND_W-1:0] k23;
  logic [RES_W-1:0]  t_sum;
  logic [OPND_W-1:0] opm;
  logic [STEP_W-1:0] coef;
  logic [RES_W-1:0]  nv_a;
  logic [RES_W-1:0]  nv_b;
  logic [RES_W-1:0]  np;

  logic [PROD_W-1:0] p_prod;
  logic [PROD_W-1:0] pos_prod;
  logic [DIV_W-1:0]  qs;
  logic [DIV_W-1:0]  qt;

  logic [DATA_W:0]   np_s;
  logic [DATA_W:0]   nv_s;
  logic [DATA_W:0]   k_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step            <= '0;
      first_position_step  <= '0;
      second_position_step <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TIME_STEP:  time_step <= cfg_data;
        REG_FIRST_POS:  first_position_step <= cfg_data;
        REG_SECOND_POS: second_position_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[S_OUT-1:0], start & ~busy};
    end
  end

  assign done = vld[S_OUT];

  always_ff @(posedge clk) begin
    in_r <= item;

    func_p[1] <= in_r.func;
    for (int i = 2; i <= S_NP; i++) begin
      func_p[i] <= func_p[i-1];
    end

    if (in_r.func == STAGE_FIRST || in_r.func == STAGE_SECOND) begin
      base_p[1] <= in_r.position;
    end else begin
      base_p[1] <= in_r.start_position;
    end
    for (int i = 2; i <= S_POS; i++) begin
      base_p[i] <= base_p[i-1];
    end

    if (in_r.func == STAGE_FIRST) begin
      nvb_p[1] <= in_r.velocity;
    end else begin
      nvb_p[1] <= in_r.start_velocity;
    end
    for (int i = 2; i <= S_QT; i++) begin
      nvb_p[i] <= nvb_p[i-1];
    end

    case (in_r.func)
      STAGE_FIRST:  ope_p[1] <= OPND_W'(sx64(in_r.velocity));
      STAGE_SECOND: ope_p[1] <= OPND_W'(sx64(in_r.k_one));
      default:      ope_p[1] <= OPND_W'(sx64(in_r.start_velocity))
                              + OPND_W'(sx64({in_r.k_two[DATA_W-1],
                                              in_r.k_two[DATA_W-1:1]}));
    endcase
    for (int i = 2; i <= S_QS; i++) begin
      ope_p[i] <= ope_p[i-1];
    end

    s_sum <= SUM_W'(sx64(in_r.k_one)) + SUM_W'(sx64(in_r.k_two))
           + SUM_W'(sx64(in_r.k_three));
    k23 <= OPND_W'(sx64(in_r.k_two)) + OPND_W'(sx64(in_r.k_three));

    k23_p[2] <= {s_sum[SUM_W-1], s_sum} + {{(TSUM_W-OPND_W){k23[OPND_W-1]}}, k23};
    for (int i = 3; i <= S_P; i++) begin
      k23_p[i] <= k23_p[i-1];
    end

    p_p[S_P+1] <= p_prod;
    for (int i = S_P + 2; i <= S_NP; i++) begin
      p_p[i] <= p_p[i-1];
    end

    t_sum <= {{(RES_W-TSUM_W){k23_p[S_P][TSUM_W-1]}}, k23_p[S_P]}
           + {p_prod[PROD_W-1], p_prod};

    if (func_p[S_QS] == STAGE_FINAL) begin
      opm <= OPND_W'(sx64(nvb_p[S_QS])) + qs[OPND_W-1:0];
    end else begin
      opm <= ope_p[S_QS];
    end

    case (func_p[S_QT]) inside
      STAGE_FIRST, STAGE_SECOND: begin
        nv_a <= sx64(nvb_p[S_QT])
              + {{2{p_p[S_QT][PROD_W-1]}}, p_p[S_QT][PROD_W-1:1]};
      end
      STAGE_THIRD: begin
        nv_a <= sx64(nvb_p[S_QT]) + {p_p[S_QT][PROD_W-1], p_p[S_QT]};
      end
      default: begin
        nv_a <= sx64(nvb_p[S_QT]) + qt;
      end
    endcase

    np   <= sx64(base_p[S_POS]) + {pos_prod[PROD_W-1], pos_prod};
    nv_b <= nv_a;
  end

  always_comb begin
    case (func_p[S_OPM])
      STAGE_FIRST:  coef = first_position_step;
      STAGE_SECOND: coef = second_position_step;
      default:      coef = time_step;
    endcase
  end

  rkn_mul u_mul_accel (
    .clk (clk),
    .a   (OPND_W'(sx64(in_r.acceleration))),
    .b   (time_step),
    .p   (p_prod)
  );

  rkn_mul u_mul_pos (
    .clk (clk),
    .a   (opm),
    .b   (coef),
    .p   (pos_prod)
  );

  rkn_div6 u_div_sum (
    .clk (clk),
    .x   ({{(DIV_W-SUM_W){s_sum[SUM_W-1]}}, s_sum}),
    .q   (qs)
  );

  rkn_div6 u_div_total (
    .clk (clk),
    .x   (t_sum),
    .q   (qt)
  );

  always_comb begin
    np_s = sat(np);
    nv_s = sat(nv_b);
    k_s  = sat({p_p[S_NP][PROD_W-1], p_p[S_NP]});
  end

  always_ff @(posedge clk) begin
    result.new_position <= np_s[DATA_W-1:0];
    result.new_velocity <= nv_s[DATA_W-1:0];
    if (func_p[S_NP] == STAGE_FINAL) begin
      result.stage_k  <= '0;
      result.overflow <= np_s[DATA_W] | nv_s[DATA_W];
    end else begin
      result.stage_k  <= k_s[DATA_W-1:0];
      result.overflow <= np_s[DATA_W] | nv_s[DATA_W] | k_s[DATA_W];
    end
  end

endmodule

@@ test/rk_nystrom_stage_update_tb.sv @@
`timescale 1ns / 1ps

module rk_nystrom_stage_update_tb;
  import rkn_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam logic [DATA_W-1:0] Q_ONE = DATA_W'(64'h1_0000_0000);

  typedef logic signed [191:0] exact_t;

  typedef enum logic [1:0] {
    SET_NOMINAL,
    SET_FULL,
    SET_ZERO,
    SET_MIXED
  } step_mode_t;

  typedef struct {
    logic    typed;
    item_t   stim;
    result_t want;
  } row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  item_t                item = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0]    cfg_data = '0;

  logic [STEP_W-1:0] step_h = '0;
  logic [STEP_W-1:0] pos_step1 = '0;
  logic [STEP_W-1:0] pos_step2 = '0;

  result_t expected_updates[$];
  row_t    rows[$];
  result_t want_r;
  int      errors = 0;
  int      checked = 0;
  int      saturated = 0;
  int      settings = 1;
  int      per_stage[4] = '{0, 0, 0, 0};
  int      cycles = 0;
  logic    burst = 1'b0;

  rk_nystrom_stage_update u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic exact_t sx(input logic [DATA_W-1:0] v);
    return {{128{v[DATA_W-1]}}, v};
  endfunction

  function automatic exact_t ux(input logic [STEP_W-1:0] v);
    return {129'b0, v};
  endfunction

  // Exact product with a step register, floored back to Q32.32.
  function automatic exact_t fmul(input exact_t x, input logic [STEP_W-1:0] s);
    return (x * ux(s)) >>> 32;
  endfunction

  function automatic exact_t floor6(input exact_t x);
    exact_t q;
    q = x / exact_t'(6);
    if (q * exact_t'(6) > x) q = q - exact_t'(1);
    return q;
  endfunction

  function automatic logic [DATA_W:0] clamp(input exact_t x);
    if (x > sx(SAT_MAX)) return {1'b1, SAT_MAX};
    if (x < sx(SAT_MIN)) return {1'b1, SAT_MIN};
    return {1'b0, x[DATA_W-1:0]};
  endfunction

  function automatic result_t stage_update(input item_t it);
    exact_t p, np, nv, s, t;
    logic [DATA_W:0] cp, cv, ck;
    result_t r;
    p = fmul(sx(it.acceleration), step_h);
    np = '0;
    nv = '0;
    ck = '0;
    case (stage_t'(it.func))
      STAGE_FIRST: begin
        np = sx(it.position) + fmul(sx(it.velocity), pos_step1);
        nv = sx(it.velocity) + (p >>> 1);
        ck = clamp(p);
      end
      STAGE_SECOND: begin
        np = sx(it.position) + fmul(sx(it.k_one), pos_step2);
        nv = sx(it.start_velocity) + (p >>> 1);
        ck = clamp(p);
      end
      STAGE_THIRD: begin
        np = sx(it.start_position)
             + fmul(sx(it.start_velocity) + (sx(it.k_two) >>> 1), step_h);
        nv = sx(it.start_velocity) + p;
        ck = clamp(p);
      end
      STAGE_FINAL: begin
        s = sx(it.k_one) + sx(it.k_two) + sx(it.k_three);
        np = sx(it.start_position) + fmul(sx(it.start_velocity) + floor6(s), step_h);
        t = s + sx(it.k_two) + sx(it.k_three) + p;
        nv = sx(it.start_velocity) + floor6(t);
      end
    endcase
    cp = clamp(np);
    cv = clamp(nv);
    r.new_position = cp[DATA_W-1:0];
    r.new_velocity = cv[DATA_W-1:0];
    r.stage_k = ck[DATA_W-1:0];
    r.overflow = cp[DATA_W] | cv[DATA_W] | ck[DATA_W];
    return r;
  endfunction

  function automatic item_t mk(input stage_t f, input logic [DATA_W-1:0] x, v, a, xs, vs,
                               k1, k2, k3);
    item_t it;
    it.func = f;
    it.position = x;
    it.velocity = v;
    it.acceleration = a;
    it.start_position = xs;
    it.start_velocity = vs;
    it.k_one = k1;
    it.k_two = k2;
    it.k_three = k3;
    return it;
  endfunction

  function automatic result_t res(input logic [DATA_W-1:0] np, nv, k, input logic ov);
    result_t r;
    r.new_position = np;
    r.new_velocity = nv;
    r.stage_k = k;
    r.overflow = ov;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return '0;
          3: return '1;
          default: return DATA_W'(1);
        endcase
      end
      1, 2: return raw;
      default: return raw >>> $urandom_range(8, 56);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    logic [STEP_W-1:0] raw;
    raw = STEP_W'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: return raw;
      1: return raw >> $urandom_range(20, 40);
      2: return '1;
      default: return '0;
    endcase
  endfunction

  function automatic item_t random_item();
    return mk(stage_t'($urandom_range(0, 3)), pick_value(), pick_value(), pick_value(),
              pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
  endfunction

  task automatic add_row(input logic typed, input item_t it, input result_t want);
    row_t r;
    r.typed = typed;
    r.stim = it;
    r.want = want;
    rows.push_back(r);
  endtask

  task automatic feed(input item_t it, input logic typed, input result_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_updates.push_back(typed ? want : stage_update(it));
    per_stage[it.func]++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
  endtask

  // The spare index is written last so that an aliasing write would show up.
  task automatic load_steps(input logic [STEP_W-1:0] h, f1, f2);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [STEP_W-1:0] val[4];
    idx[0] = REG_TIME_STEP;
    idx[1] = REG_FIRST_POS;
    idx[2] = REG_SECOND_POS;
    idx[3] = REG_SPARE;
    val[0] = h;
    val[1] = f1;
    val[2] = f2;
    val[3] = STEP_W'({$urandom, $urandom});
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      case (idx[i])
        REG_TIME_STEP: step_h = val[i];
        REG_FIRST_POS: pos_step1 = val[i];
        REG_SECOND_POS: pos_step2 = val[i];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
    settings++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rk_nystrom_stage_update_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_updates.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing outstanding: %h", result);
      end else begin
        want_r = expected_updates.pop_front();
        checked++;
        saturated += result.overflow;
        if (result.new_position !== want_r.new_position
            || result.new_velocity !== want_r.new_velocity
            || result.stage_k !== want_r.stage_k
            || result.overflow !== want_r.overflow) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: pos %h/%h vel %h/%h k %h/%h ovf %b/%b (got/want)",
                     result.new_position, want_r.new_position,
                     result.new_velocity, want_r.new_velocity,
                     result.stage_k, want_r.stage_k,
                     result.overflow, want_r.overflow);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // With every step register at zero the outcome can be read directly.
    add_row(1'b1, mk(STAGE_FIRST, SAT_MAX, SAT_MAX, '0, '0, '0, '0, '0, '0),
            res(SAT_MAX, SAT_MAX, '0, 1'b0));
    add_row(1'b1, mk(STAGE_SECOND, SAT_MIN, '0, SAT_MAX, '0, SAT_MIN, SAT_MAX, '0, '0),
            res(SAT_MIN, SAT_MIN, '0, 1'b0));
    add_row(1'b1, mk(STAGE_THIRD, '0, '0, '0, SAT_MAX, SAT_MIN, '0, SAT_MIN, '0),
            res(SAT_MAX, SAT_MIN, '0, 1'b0));
    add_row(1'b1, mk(STAGE_FINAL, '0, '0, '0, Q_ONE, SAT_MAX, 64'd6, 64'd6, 64'd6),
            res(Q_ONE, SAT_MAX, '0, 1'b1));
    add_row(1'b1, mk(STAGE_FINAL, '0, '0, '0, '0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN),
            res('0, SAT_MIN, '0, 1'b1));
    add_row(1'b1, mk(STAGE_FIRST, '1, SAT_MIN, SAT_MAX, '0, '0, '0, '0, '0),
            res('1, SAT_MIN, '0, 1'b0));
    add_row(1'b0, mk(STAGE_FIRST, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                     SAT_MAX, SAT_MAX), '0);
    add_row(1'b0, mk(STAGE_FIRST, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                     SAT_MIN, SAT_MIN), '0);
    add_row(1'b0, mk(STAGE_SECOND, SAT_MAX, Q_ONE, SAT_MIN, '0, SAT_MAX, SAT_MAX, '1, '0),
            '0);
    add_row(1'b0, mk(STAGE_SECOND, '0, '1, 64'd1, '0, '1, SAT_MIN, '0, '1), '0);
    add_row(1'b0, mk(STAGE_THIRD, '0, '0, SAT_MAX, SAT_MIN, SAT_MIN, '0, SAT_MIN, '0),
            '0);
    add_row(1'b0, mk(STAGE_THIRD, '1, '1, '1, Q_ONE, SAT_MAX, '1, SAT_MAX, '1), '0);
    add_row(1'b0, mk(STAGE_FINAL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                     SAT_MAX, SAT_MAX), '0);
    add_row(1'b0, mk(STAGE_FINAL, '0, '0, '0, '0, '0, '1, '0, '0), '0);

    foreach (rows[i]) if (rows[i].typed) feed(rows[i].stim, 1'b1, rows[i].want);
    drain();
    load_steps(STEP_W'(64'h1_0000_0000), STEP_W'(64'h8000_0000), STEP_W'(64'h4000_0000));
    foreach (rows[i]) if (!rows[i].typed) feed(rows[i].stim, 1'b0, '0);
    drain();
    load_steps('1, '1, '1);
    foreach (rows[i]) if (!rows[i].typed) feed(rows[i].stim, 1'b0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      logic [STEP_W-1:0] h;
      drain();
      h = (STEP_W'($urandom_range(0, 3)) << 32) | STEP_W'($urandom);
      case (step_mode_t'(ph % 4))
        SET_NOMINAL: load_steps(h, h >> 1, h >> 2);
        SET_FULL: load_steps('1, '1, '1);
        SET_ZERO: load_steps('0, '0, '0);
        SET_MIXED: load_steps(pick_step(), pick_step(), pick_step());
      endcase
      for (int n = 0; n < 64; n++) feed(random_item(), 1'b0, '0);
    end

    drain();
    repeat (24) @(posedge clk);
    $display("stage items sent: first %0d, second %0d, third %0d, final %0d",
             per_stage[STAGE_FIRST], per_stage[STAGE_SECOND], per_stage[STAGE_THIRD],
             per_stage[STAGE_FINAL]);
    $display("%0d results checked under %0d step settings, %0d saturated, %0d failures",
             checked, settings, saturated, errors);
    if (errors == 0) begin
      $display("rk_nystrom_stage_update_tb: clean");
    end else begin
      $display("rk_nystrom_stage_update_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rkn_pkg.sv
hw/rtl/rkn_mul.sv
hw/rtl/rkn_div6.sv
hw/rtl/rk_nystrom_stage_update.sv
test/rk_nystrom_stage_update_tb.sv
